// ===== sv/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pkg
// Types and constants for the age-counter LRU page replacement block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru_pkg;

	localparam int FRAMES    = 16;
	localparam int AGE_BITS  = 16;
	localparam int PAGE_BITS = 16;
	localparam int IDX_BITS  = $clog2(FRAMES);
	localparam int CNT_BITS  = IDX_BITS + 1;
	localparam int REG_BITS  = 5;
	localparam int ADDR_BITS = 3;

	localparam logic [REG_BITS-1:0]  FRAMES_RESET = REG_BITS'(FRAMES);
	localparam logic [CNT_BITS-1:0]  CAP_MAX      = CNT_BITS'(FRAMES);
	localparam logic [AGE_BITS-1:0]  AGE_MAX      = '1;
	localparam logic [31:0]          TOTAL_MAX    = '1;

	// register select: bit 2 of the byte address
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [15:0] page_number;
		logic        last_reference;
	} req_item_t;

	typedef struct packed {
		logic        hit;
		logic        counted_fault;
		logic [3:0]  frame_index;
		logic        evicted_valid;
		logic [15:0] evicted_page;
		logic [31:0] miss_count;
		logic [31:0] reference_count;
		logic        run_done;
	} rsp_item_t;

endpackage

// ===== sv/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// An accepted item passes through SCAN (skipped when no frame is filled), FIN
// and OUT; the next item is taken only in IDLE, after the result is taken. A
// single age/compare unit walks the frames one per cycle, then FIN writes back.
// Reset clears fill count, both counters and the handshake; frames_in_use
// returns to 16. Frame contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_page_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lru_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  lru_pkg::req_item_t             req_item,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output lru_pkg::rsp_item_t             rsp_item
);

	lru_pkg::state_t state_q;

	logic [lru_pkg::REG_BITS-1:0]  frames_in_use_q;
	logic [lru_pkg::CNT_BITS-1:0]  filled_q;
	logic [31:0]                   fault_total_q;
	logic [31:0]                   ref_total_q;

	logic [lru_pkg::PAGE_BITS-1:0] pages_q [lru_pkg::FRAMES];
	logic [lru_pkg::AGE_BITS-1:0]  ages_q  [lru_pkg::FRAMES];

	logic [lru_pkg::PAGE_BITS-1:0] page_q;
	logic                          last_q;
	logic [lru_pkg::CNT_BITS-1:0]  scan_q;
	logic                          hit_q;
	logic [lru_pkg::IDX_BITS-1:0]  hit_idx_q;
	logic [lru_pkg::AGE_BITS-1:0]  best_age_q;
	logic [lru_pkg::IDX_BITS-1:0]  best_idx_q;
	logic [lru_pkg::PAGE_BITS-1:0] best_page_q;

	lru_pkg::rsp_item_t            rsp_q;
	logic                          rsp_valid_q;

	logic                          cfg_wr;
	logic                          req_take;
	logic                          rsp_take;
	logic [lru_pkg::CNT_BITS-1:0]  cap;
	logic                          full;
	logic [lru_pkg::IDX_BITS-1:0]  sidx;
	logic [lru_pkg::PAGE_BITS-1:0] page_rd;
	logic [lru_pkg::AGE_BITS-1:0]  age_rd;
	logic                          match;
	logic [lru_pkg::AGE_BITS-1:0]  age_nx;
	logic                          scan_last;
	logic [lru_pkg::IDX_BITS-1:0]  fin_idx;
	logic                          fin_write;
	logic                          fin_fault;
	logic [31:0]                   fault_nx;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == lru_pkg::REG_FRAMES_IN_USE);
	assign prdata    = (paddr[2] == lru_pkg::REG_FRAMES_IN_USE)
		? {{(32-lru_pkg::REG_BITS){1'b0}}, frames_in_use_q} : 32'd0;

	assign req_stall = (state_q != lru_pkg::ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign rsp_take  = rsp_valid_q && !rsp_stall;

	always_comb begin
		if (frames_in_use_q == '0) begin
			cap = lru_pkg::CNT_BITS'(1);
		end else if (lru_pkg::CNT_BITS'(frames_in_use_q) > lru_pkg::CAP_MAX) begin
			cap = lru_pkg::CAP_MAX;
		end else begin
			cap = lru_pkg::CNT_BITS'(frames_in_use_q);
		end
	end

	assign full      = (filled_q >= cap);
	assign sidx      = scan_q[lru_pkg::IDX_BITS-1:0];
	assign page_rd   = pages_q[sidx];
	assign age_rd    = ages_q[sidx];
	assign match     = (page_rd == page_q);
	assign scan_last = ((scan_q + 1'b1) == filled_q);

	always_comb begin
		if (match) begin
			age_nx = '0;
		end else if (age_rd == lru_pkg::AGE_MAX) begin
			age_nx = age_rd;
		end else begin
			age_nx = age_rd + 1'b1;
		end
	end

	always_comb begin
		fin_write = 1'b0;
		fin_fault = 1'b0;
		fin_idx   = hit_idx_q;
		if (!hit_q) begin
			fin_write = 1'b1;
			if (!full) begin
				fin_idx = filled_q[lru_pkg::IDX_BITS-1:0];
			end else begin
				fin_idx   = best_idx_q;
				fin_fault = 1'b1;
			end
		end
		fault_nx = fault_total_q;
		if (fin_fault && (fault_total_q != lru_pkg::TOTAL_MAX)) begin
			fault_nx = fault_total_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lru_pkg::ST_SCAN) begin
			ages_q[sidx] <= age_nx;
		end else if ((state_q == lru_pkg::ST_FIN) && fin_write) begin
			pages_q[fin_idx] <= page_q;
			ages_q[fin_idx]  <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			page_q <= req_item.page_number;
			last_q <= req_item.last_reference;
		end
		if (state_q == lru_pkg::ST_SCAN) begin
			if (match && !hit_q) begin
				hit_idx_q <= sidx;
			end
			if ((scan_q == '0) || (age_nx > best_age_q)) begin
				best_age_q  <= age_nx;
				best_idx_q  <= sidx;
				best_page_q <= page_rd;
			end
		end
		if (state_q == lru_pkg::ST_FIN) begin
			rsp_q.hit             <= hit_q;
			rsp_q.counted_fault   <= fin_fault;
			rsp_q.frame_index     <= 4'(fin_idx);
			rsp_q.evicted_valid   <= fin_fault;
			rsp_q.evicted_page    <= fin_fault ? 16'(best_page_q) : 16'd0;
			rsp_q.miss_count      <= fault_nx;
			rsp_q.reference_count <= ref_total_q;
			rsp_q.run_done        <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= lru_pkg::ST_IDLE;
			frames_in_use_q <= lru_pkg::FRAMES_RESET;
			filled_q        <= '0;
			fault_total_q   <= '0;
			ref_total_q     <= '0;
			scan_q          <= '0;
			hit_q           <= 1'b0;
			rsp_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				frames_in_use_q <= pwdata[lru_pkg::REG_BITS-1:0];
			end
			unique case (state_q)
				lru_pkg::ST_IDLE: begin
					if (req_take) begin
						scan_q <= '0;
						hit_q  <= 1'b0;
						if (full && (ref_total_q != lru_pkg::TOTAL_MAX)) begin
							ref_total_q <= ref_total_q + 32'd1;
						end
						state_q <= (filled_q == '0) ? lru_pkg::ST_FIN : lru_pkg::ST_SCAN;
					end
				end
				lru_pkg::ST_SCAN: begin
					if (match) begin
						hit_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						state_q <= lru_pkg::ST_FIN;
					end
				end
				lru_pkg::ST_FIN: begin
					rsp_valid_q <= 1'b1;
					if (last_q) begin
						filled_q      <= '0;
						fault_total_q <= '0;
						ref_total_q   <= '0;
					end else begin
						fault_total_q <= fault_nx;
						if (!hit_q && !full) begin
							filled_q <= filled_q + 1'b1;
						end
					end
					state_q <= lru_pkg::ST_OUT;
				end
				lru_pkg::ST_OUT: begin
					if (rsp_take) begin
						rsp_valid_q <= 1'b0;
						state_q     <= lru_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lru_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
